[sv/translation_miss_handler_assert.svh]
// ----------------------------------------------------------------------------
// Translation miss handler assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRANSLATION_MISS_HANDLER_ASSERT_SVH
`define TRANSLATION_MISS_HANDLER_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define TMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tmh_pkg.sv]
// ----------------------------------------------------------------------------
// Translation miss handler package
// Word types, codes and sizing constants shared by the miss handler.
// ----------------------------------------------------------------------------
package tmh_pkg;

  localparam int NUM_SLOTS    = 32;
  localparam int RECENT_DEPTH = 8;
  localparam int PAGE_BITS    = 12;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RING_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int CFG_W  = 4;

  localparam logic [31:0] PAGE_MASK = ~32'((64'(1) << PAGE_BITS) - 64'(1));
  localparam logic [2:0]  CORE_SOURCE = 3'h2;

  typedef enum logic [1:0] {
    ACT_MISS    = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_UNKNOWN = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RS_MAPPED      = 3'd0,
    RS_NOT_NEEDED  = 3'd1,
    RS_OWN_SKIPPED = 3'd2,
    RS_FAULT       = 3'd3,
    RS_WALK_FAILED = 3'd4,
    RS_REMOVED     = 3'd5,
    RS_CLEARED     = 3'd6
  } status_t;

  typedef enum logic {
    CFG_OWN_CLUSTER = 1'b0,
    CFG_OWN_CORE    = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] vaddr;
    logic [2:0]  source_class;
    logic [3:0]  src_cluster;
    logic [3:0]  src_core;
    logic        from_prefetch;
    logic        already_present;
    logic        walk_ok;
    logic [31:0] phys_page;
    logic        walk_read_only;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_status;
    logic [4:0]  slot_index;
    logic [31:0] page_base;
    logic [31:0] phys_base;
    logic        slot_read_only;
    logic        wake;
    logic [3:0]  wake_cluster;
    logic [15:0] wake_core_mask;
  } out_word_t;

endpackage

[sv/translation_miss_handler.sv]
// ----------------------------------------------------------------------------
// Translation miss handler
// Sorts miss, unmap and clear words, scans the ring of recently mapped pages
// with one shared comparator and hands out translation slots in FIFO order.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Word
//  input     start && !busy          item   (in_word_t)
//  result    done, one cycle         result (out_word_t)
//  config    cfg_we                  cfg_index, cfg_wdata
//
// A miss or unmap word steps through the ring one entry per cycle with the single
// page comparator, then passes through a finish state before done.
// A clear word goes straight to the finish state; an unknown action gives no result.
// busy is high from the cycle after start until done; the result cannot be
// stalled. Reset empties the ring and restarts both pointers.
module translation_miss_handler (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tmh_pkg::in_word_t  item,
  output logic               busy,
  output logic               done,
  output tmh_pkg::out_word_t result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata
);
  import tmh_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [RING_W-1:0] scan_idx;
  logic              scan_last;
  logic              finish;
  logic              accept;
  logic              hit;
  logic [31:0]       ring [RECENT_DEPTH];
  logic [RING_W-1:0] ring_wptr;
  logic [SLOT_W-1:0] slot_ptr;
  logic [3:0]        own_cluster;
  logic [3:0]        own_core;
  in_word_t          cur;
  logic [31:0]       page;
  logic              page_match;
  logic              mapped;
  out_word_t         result_next;

  assign accept    = start && !busy;
  assign scan_last = (scan_idx == RING_W'(RECENT_DEPTH - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (item.action == ACT_MISS || item.action == ACT_REMOVE) begin
            state_next = S_SCAN;
          end else if (item.action == ACT_CLEAR) begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != S_IDLE);
    finish = (state == S_FINISH);
  end

  assign page_match = (ring[scan_idx] == page);

  always_comb begin
    result_next = '0;
    mapped      = 1'b0;
    priority if (cur.action == ACT_CLEAR) begin
      result_next.result_status = RS_CLEARED;
    end else if (cur.action == ACT_REMOVE) begin
      result_next.result_status = RS_REMOVED;
      result_next.page_base     = page;
    end else if (cur.source_class != CORE_SOURCE) begin
      result_next.result_status = RS_FAULT;
      result_next.page_base     = page;
    end else if (cur.src_cluster == own_cluster && cur.src_core == own_core) begin
      result_next.result_status = RS_OWN_SKIPPED;
      result_next.page_base     = page;
    end else if (hit || cur.already_present) begin
      result_next.result_status = RS_NOT_NEEDED;
      result_next.page_base     = page;
      result_next.wake          = !cur.from_prefetch;
    end else if (!cur.walk_ok) begin
      result_next.result_status = RS_WALK_FAILED;
      result_next.page_base     = page;
    end else begin
      mapped                     = 1'b1;
      result_next.result_status  = RS_MAPPED;
      result_next.slot_index     = 5'(slot_ptr);
      result_next.page_base      = page;
      result_next.phys_base      = cur.phys_page;
      result_next.slot_read_only = cur.walk_read_only;
      result_next.wake           = !cur.from_prefetch;
    end
    if (result_next.wake) begin
      result_next.wake_cluster   = cur.src_cluster;
      result_next.wake_core_mask = 16'(1) << cur.src_core;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      scan_idx    <= '0;
      hit         <= 1'b0;
      ring_wptr   <= '0;
      slot_ptr    <= '0;
      own_cluster <= '0;
      own_core    <= '0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= finish;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OWN_CLUSTER: own_cluster <= cfg_wdata;
          CFG_OWN_CORE:    own_core    <= cfg_wdata;
          default:         own_core    <= own_core;
        endcase
      end
      if (accept) begin
        hit      <= 1'b0;
        scan_idx <= '0;
      end
      if (state == S_SCAN) begin
        if (page_match && page != '0) begin
          hit <= 1'b1;
        end
        if (page_match && cur.action == ACT_REMOVE) begin
          ring[scan_idx] <= '0;
        end
        scan_idx <= scan_last ? '0 : scan_idx + RING_W'(1);
      end
      if (finish) begin
        if (cur.action == ACT_CLEAR) begin
          ring_wptr <= '0;
          slot_ptr  <= '0;
          for (int i = 0; i < RECENT_DEPTH; i++) begin
            ring[i] <= '0;
          end
        end else if (mapped) begin
          ring[ring_wptr] <= page;
          ring_wptr <= (ring_wptr == RING_W'(RECENT_DEPTH - 1)) ? '0 : ring_wptr + RING_W'(1);
          slot_ptr  <= (slot_ptr == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_ptr + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= item;
      page <= (item.action == ACT_CLEAR) ? '0 : (item.vaddr & PAGE_MASK);
    end
    if (finish) begin
      result <= result_next;
    end
  end

`include "translation_miss_handler_assert.svh"

  `TMH_ASSERT(a_done_after_finish, done |-> $past(state == S_FINISH),
              "done without finish")
  `TMH_ASSERT(a_unknown_ignored, (accept && item.action == ACT_UNKNOWN) |=> !busy,
              "unknown action taken")
  `TMH_ASSERT(a_wake_status,
              (done && result.wake) |-> (result.result_status == RS_MAPPED ||
                                         result.result_status == RS_NOT_NEEDED),
              "wake with wrong status")
  `TMH_ASSERT(a_wake_mask,
              done |-> (result.wake ? $onehot(result.wake_core_mask) :
                                      (result.wake_core_mask == '0)),
              "bad wake mask")
  `TMH_ASSERT_ALWAYS(a_scan_idle, (state != S_SCAN) |-> (scan_idx == '0),
                     "scan index left over")

endmodule

[tb/tmh_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Translation miss handler result checker
// Watches the input, configuration and result channels of the miss handler,
// keeps its own copy of the recent-page ring, the slot FIFO pointer and the
// own-core registers, predicts the result word of each accepted word with a known
// action and compares every result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tmh_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  tmh_pkg::in_word_t   item,
  input  logic                done,
  input  tmh_pkg::out_word_t  result,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  checked_count,
  output int                  mapped_count
);
  import tmh_pkg::*;

  logic [31:0] recent_pages [RECENT_DEPTH];
  int unsigned ring_wr_ptr;
  int unsigned next_slot;
  logic [3:0]  own_cluster;
  logic [3:0]  own_core;
  out_word_t   expected_results [$];

  function automatic bit predict_outcome(input in_word_t w, output out_word_t r);
    logic [31:0] page;
    bit          hit;
    r = '0;
    page = w.vaddr & PAGE_MASK;
    r.page_base = page;
    case (w.action)
      ACT_CLEAR: begin
        foreach (recent_pages[i]) recent_pages[i] = '0;
        ring_wr_ptr = 0;
        next_slot = 0;
        r.result_status = RS_CLEARED;
        r.page_base = '0;
      end
      ACT_REMOVE: begin
        foreach (recent_pages[i]) begin
          if (recent_pages[i] == page) recent_pages[i] = '0;
        end
        r.result_status = RS_REMOVED;
      end
      ACT_MISS: begin
        hit = 1'b0;
        if (page != '0) begin
          foreach (recent_pages[i]) begin
            if (recent_pages[i] == page) hit = 1'b1;
          end
        end
        if (w.source_class != CORE_SOURCE) begin
          r.result_status = RS_FAULT;
        end else if (w.src_cluster == own_cluster && w.src_core == own_core) begin
          r.result_status = RS_OWN_SKIPPED;
        end else if (hit || w.already_present) begin
          r.result_status = RS_NOT_NEEDED;
          r.wake = !w.from_prefetch;
        end else if (!w.walk_ok) begin
          r.result_status = RS_WALK_FAILED;
        end else begin
          r.result_status = RS_MAPPED;
          r.slot_index = 5'(next_slot);
          next_slot = (next_slot + 1) % NUM_SLOTS;
          recent_pages[ring_wr_ptr] = page;
          ring_wr_ptr = (ring_wr_ptr + 1) % RECENT_DEPTH;
          r.phys_base = w.phys_page;
          r.slot_read_only = w.walk_read_only;
          r.wake = !w.from_prefetch;
        end
      end
      default: return 1'b0;
    endcase
    if (r.wake) begin
      r.wake_cluster = w.src_cluster;
      r.wake_core_mask = 16'(1) << w.src_core;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_word;
    out_word_t new_word;
    if (rst) begin
      foreach (recent_pages[i]) recent_pages[i] = '0;
      ring_wr_ptr = 0;
      next_slot = 0;
      own_cluster = '0;
      own_core = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_OWN_CLUSTER) own_cluster = cfg_wdata;
        else own_core = cfg_wdata;
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result word 0x%0h arrived with no word pending", result);
          fail_count++;
        end else begin
          exp_word = expected_results.pop_front();
          check_field("result_status", 32'(exp_word.result_status),
                      32'(result.result_status));
          check_field("slot_index", 32'(exp_word.slot_index), 32'(result.slot_index));
          check_field("page_base", exp_word.page_base, result.page_base);
          check_field("phys_base", exp_word.phys_base, result.phys_base);
          check_field("slot_read_only", 32'(exp_word.slot_read_only),
                      32'(result.slot_read_only));
          check_field("wake", 32'(exp_word.wake), 32'(result.wake));
          check_field("wake_cluster", 32'(exp_word.wake_cluster),
                      32'(result.wake_cluster));
          check_field("wake_core_mask", 32'(exp_word.wake_core_mask),
                      32'(result.wake_core_mask));
          checked_count++;
          if (exp_word.result_status == RS_MAPPED) mapped_count++;
        end
      end
      if (start && !busy) begin
        if (predict_outcome(item, new_word)) expected_results.push_back(new_word);
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/tb_translation_miss_handler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Translation miss handler testbench
// Drives a directed set of miss, unmap, clear and unknown words, then random
// phases under several own-core settings, with random sender gaps and one
// gap-free phase. A separate checker predicts and compares all result words.
// ----------------------------------------------------------------------------
module tb_translation_miss_handler;
  import tmh_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int LATENCY        = 10;
  localparam int SETTLE_CYCLES  = 2 * LATENCY;
  localparam int NUM_PHASES     = 5;
  localparam int WORDS_PER_PHASE = 290;
  localparam int POOL_SIZE      = 12;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       done;
  in_word_t   item;
  out_word_t  result;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic [3:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked_count;
  int mapped_count;

  int          words_sent;
  int          ignored_sent;
  int          settings_used;
  bit          gap_free;
  logic [3:0]  own_cl;
  logic [3:0]  own_co;
  logic [31:0] page_pool [POOL_SIZE];

  translation_miss_handler u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tmh_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .done          (done),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .mapped_count  (mapped_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(input in_word_t w);
    if (!gap_free && $urandom_range(0, 99) < 50) begin
      @(negedge clk);
      start <= 1'b0;
      while (busy) @(negedge clk);
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    if (w.action == ACT_UNKNOWN) ignored_sent++;
    else words_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_owner(input logic [3:0] cl, input logic [3:0] co);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWN_CLUSTER;
    cfg_wdata <= cl;
    @(negedge clk);
    cfg_index <= CFG_OWN_CORE;
    cfg_wdata <= co;
    @(negedge clk);
    cfg_we <= 1'b0;
    own_cl = cl;
    own_co = co;
    settings_used++;
  endtask

  function automatic in_word_t miss_word(input logic [31:0] va, input logic [3:0] cl,
                                         input logic [3:0] co);
    in_word_t w;
    w = '0;
    w.action = ACT_MISS;
    w.vaddr = va;
    w.source_class = CORE_SOURCE;
    w.src_cluster = cl;
    w.src_core = co;
    w.walk_ok = 1'b1;
    w.phys_page = $urandom;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.action = 2'($urandom_range(0, 3));
    w.vaddr = $urandom;
    w.source_class = 3'($urandom_range(0, 7));
    w.src_cluster = 4'($urandom_range(0, 15));
    w.src_core = 4'($urandom_range(0, 15));
    w.from_prefetch = 1'($urandom_range(0, 1));
    w.already_present = 1'($urandom_range(0, 1));
    w.walk_ok = 1'($urandom_range(0, 1));
    w.phys_page = $urandom;
    w.walk_read_only = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      w.action = ACT_MISS;
      w.source_class = CORE_SOURCE;
      w.vaddr = page_pool[$urandom_range(0, POOL_SIZE - 1)] | ($urandom & ~PAGE_MASK);
      w.already_present = ($urandom_range(0, 99) < 15);
      w.walk_ok = ($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 99) < 5) begin
        w.src_cluster = own_cl;
        w.src_core = own_co;
      end
    end else if (pick < 80) begin
      w.action = ACT_REMOVE;
      w.vaddr = page_pool[$urandom_range(0, POOL_SIZE - 1)] | ($urandom & ~PAGE_MASK);
    end else if (pick < 82) begin
      w.action = ACT_CLEAR;
    end else if (pick < 86) begin
      w.action = ACT_UNKNOWN;
    end else if (pick < 93) begin
      w.action = ACT_MISS;
    end
    return w;
  endfunction

  task automatic run_directed();
    in_word_t w;
    w = miss_word(32'hFFFF_FFFF, 4'd1, 4'd2);
    w.source_class = 3'd0;
    send_word(w);
    w.source_class = 3'd7;
    send_word(w);
    w = miss_word(32'h1234_5678, 4'd3, 4'd5);
    send_word(w);
    w = miss_word(32'h1234_5678, 4'd15, 4'd15);
    w.phys_page = 32'hFFFF_FFFF;
    w.walk_read_only = 1'b1;
    send_word(w);
    w = miss_word(32'h1234_5ABC, 4'd1, 4'd0);
    send_word(w);
    w.from_prefetch = 1'b1;
    send_word(w);
    w = miss_word(32'h8765_4321, 4'd2, 4'd9);
    w.already_present = 1'b1;
    send_word(w);
    w = miss_word(32'hABCD_E000, 4'd2, 4'd9);
    w.walk_ok = 1'b0;
    send_word(w);
    w.walk_ok = 1'b1;
    w.from_prefetch = 1'b1;
    w.phys_page = '0;
    send_word(w);
    w = miss_word(32'h0000_0FFF, 4'd0, 4'd0);
    send_word(w);
    send_word(w);
    w.action = ACT_REMOVE;
    send_word(w);
    w = miss_word(32'h1234_5000, 4'd6, 4'd1);
    w.action = ACT_REMOVE;
    send_word(w);
    w.action = ACT_MISS;
    send_word(w);
    w.action = ACT_UNKNOWN;
    send_word(w);
    w.action = ACT_CLEAR;
    send_word(w);
    w.action = ACT_MISS;
    send_word(w);
    w = miss_word(32'hFFFF_F000, 4'd0, 4'd0);
    send_word(w);
    w = miss_word(32'h0BAD_0000, 4'd7, 4'd7);
    w.action = ACT_REMOVE;
    send_word(w);
  endtask

  initial begin
    logic [3:0] phase_cl [NUM_PHASES];
    logic [3:0] phase_co [NUM_PHASES];
    int         target;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_OWN_CLUSTER;
    cfg_wdata = '0;
    words_sent = 0;
    ignored_sent = 0;
    settings_used = 0;
    gap_free = 1'b0;
    own_cl = '0;
    own_co = '0;
    phase_cl = '{4'd0, 4'd15, 4'd0, 4'd15, 4'($urandom_range(1, 14))};
    phase_co = '{4'd0, 4'd15, 4'd15, 4'd0, 4'($urandom_range(1, 14))};
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    write_owner(4'd3, 4'd5);
    run_directed();
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_owner(phase_cl[p], phase_co[p]);
      foreach (page_pool[i]) page_pool[i] = $urandom & PAGE_MASK;
      page_pool[0] = '0;
      gap_free = (p == 2);
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) send_word(random_word());
      settle();
    end

    $display("Sent %0d words (%0d more with unknown action) under %0d own-core settings.",
             words_sent, ignored_sent, settings_used);
    $display("Compared %0d result words, %0d of them new slot mappings.",
             checked_count, mapped_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
